>>> rtl/tlpm_pkg.sv
// shared types and constants for the trie longest prefix match block
`timescale 1ns / 1ps

package tlpm_pkg;

    localparam int NODE_COUNT = 65536;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;
    localparam int HOP_W      = 16;
    localparam int ROW_W      = 2 * NODE_W;
    localparam int NODE_MEM_W = HOP_W + 1;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 24;

    localparam logic [PLEN_W-1:0] MAX_LEVELS = PLEN_W'(ADDR_W);
    localparam logic [FREE_W-1:0] POOL_END   = FREE_W'(NODE_COUNT);

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_INSERT   = 1'b1;
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LK_WALK,
        ST_INS_WALK,
        ST_INS_CLR,
        ST_FIN
    } state_t;

endpackage

>>> rtl/tlpm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tlpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/trie_longest_prefix_match.sv
// binary trie route table with insert and longest prefix lookup
//
//  port group  dir  fields (low bit first)
//  s_*         in   tuser: opcode; tdata: address, prefix_len, next_hop
//  m_*         out  tdata: found, match_hop, status
//
//  lookup: one node memory read per trie level, up to 33 levels
//  insert: walks one level at a time and allocates a new node for each missing child
//  after reset an init state clears the root node before the first word
//  a finished result waits in the output register; the next word is taken meanwhile
`timescale 1ns / 1ps

module trie_longest_prefix_match
    import tlpm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // address, prefix_len, next_hop
    input  logic                s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // found, match_hop, status
);

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PLEN_W-1:0]   rem_reg, rem_next;
    logic                fresh_reg, fresh_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic                hit_reg, hit_next;
    logic [HOP_W-1:0]    res_hop_reg, res_hop_next;
    logic                status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                child_we, node_we;
    logic [NODE_W-1:0]   child_waddr, node_waddr, rd_addr;
    logic [ROW_W-1:0]    child_wdata, child_rdata, row;
    logic [NODE_MEM_W-1:0] node_wdata, node_rdata;
    logic [NODE_W-1:0]   child;
    logic                slot, accept, pool_full, out_free;
    logic [PLEN_W-1:0]   in_plen;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign row       = fresh_reg ? '0 : child_rdata;
    assign slot      = addr_reg[ADDR_W-1];
    assign child     = slot ? row[ROW_W-1:NODE_W] : row[NODE_W-1:0];
    assign pool_full = (free_reg == POOL_END);
    assign out_free  = !m_valid_reg || m_tready;
    assign in_plen   = s_tdata[ADDR_W +: PLEN_W];
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    tlpm_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NODE_COUNT)
    ) u_child_ram (
        .aclk (aclk),
        .we   (child_we),
        .waddr(child_waddr),
        .wdata(child_wdata),
        .raddr(rd_addr),
        .rdata(child_rdata)
    );

    tlpm_ram #(
        .WIDTH(NODE_MEM_W),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .aclk (aclk),
        .we   (node_we),
        .waddr(node_waddr),
        .wdata(node_wdata),
        .raddr(rd_addr),
        .rdata(node_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == OP_INSERT) ? ST_INS_WALK : ST_LK_WALK;
                end
            end
            ST_LK_WALK: begin
                if (rem_reg == '0 || child == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_INS_WALK: begin
                if (rem_reg == '0) begin
                    state_next = ST_FIN;
                end else if (child == '0) begin
                    state_next = pool_full ? ST_FIN : ST_INS_CLR;
                end
            end
            ST_INS_CLR: begin
                state_next = ST_INS_WALK;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        node_next    = node_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        fresh_next   = fresh_reg;
        free_next    = free_reg;
        hop_next     = hop_reg;
        hit_next     = hit_reg;
        res_hop_next = res_hop_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rd_addr      = child;
        child_we     = 1'b0;
        child_waddr  = node_reg;
        child_wdata  = '0;
        node_we      = 1'b0;
        node_waddr   = node_reg;
        node_wdata   = '0;
        unique case (state_reg)
            ST_INIT: begin
                child_we    = 1'b1;
                child_waddr = '0;
                node_we     = 1'b1;
                node_waddr  = '0;
            end
            ST_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    node_next    = '0;
                    addr_next    = s_tdata[ADDR_W-1:0];
                    hop_next     = s_tdata[ADDR_W+PLEN_W +: HOP_W];
                    fresh_next   = 1'b0;
                    hit_next     = 1'b0;
                    res_hop_next = '0;
                    status_next  = STATUS_DONE;
                    if (s_tuser == OP_INSERT && in_plen <= MAX_LEVELS) begin
                        rem_next = in_plen;
                    end else begin
                        rem_next = MAX_LEVELS;
                    end
                end
            end
            ST_LK_WALK: begin
                if (node_rdata[HOP_W]) begin
                    hit_next     = 1'b1;
                    res_hop_next = node_rdata[HOP_W-1:0];
                end
                node_next = child;
                addr_next = {addr_reg[ADDR_W-2:0], 1'b0};
                rem_next  = rem_reg - PLEN_W'(1);
            end
            ST_INS_WALK: begin
                if (rem_reg == '0) begin
                    node_we    = 1'b1;
                    node_wdata = {1'b1, hop_reg};
                end else if (child != '0) begin
                    node_next = child;
                    addr_next = {addr_reg[ADDR_W-2:0], 1'b0};
                    rem_next  = rem_reg - PLEN_W'(1);
                end else if (pool_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    child_we    = 1'b1;
                    child_wdata = slot ? {free_reg[NODE_W-1:0], row[NODE_W-1:0]}
                                       : {row[ROW_W-1:NODE_W], free_reg[NODE_W-1:0]};
                    node_we     = 1'b1;
                    node_waddr  = free_reg[NODE_W-1:0];
                    node_next   = free_reg[NODE_W-1:0];
                    free_next   = free_reg + FREE_W'(1);
                    addr_next   = {addr_reg[ADDR_W-2:0], 1'b0};
                    rem_next    = rem_reg - PLEN_W'(1);
                end
            end
            ST_INS_CLR: begin
                child_we   = 1'b1;
                fresh_next = 1'b1;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, status_reg, res_hop_reg, hit_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            free_reg    <= FREE_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
        node_reg    <= node_next;
        addr_reg    <= addr_next;
        rem_reg     <= rem_next;
        fresh_reg   <= fresh_next;
        hop_reg     <= hop_next;
        hit_reg     <= hit_next;
        res_hop_reg <= res_hop_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg != '0 && free_reg <= POOL_END)
        else $error("node pool counter out of range");

    a_free_step: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg != $past(free_reg) |-> state_reg == ST_INS_CLR)
        else $error("node allocated outside insert walk");

    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[HOP_W+1])
        else $error("lookup hit reported with pool full status");

    a_walk_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LK_WALK || state_reg == ST_INS_WALK) |-> rem_reg <= MAX_LEVELS)
        else $error("trie walk deeper than address width");

endmodule
